/* rtl/krpq_pkg.sv */
// Package with the word types, codes and sizes of the keyframe recovery packet queue.
package krpq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int TAG_BITS = 16;
    localparam int FILL_W = 7;
    localparam int CNT_W = 32;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(QUEUE_DEPTH);

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic REG_QUEUE_LIMIT = 1'b0;

    typedef struct packed {
        logic [1:0]          action;
        logic [TAG_BITS-1:0] packet_tag;
        logic                key_frame;
    } t_in_word;

    typedef struct packed {
        logic                accepted;
        logic                pop_valid;
        logic [TAG_BITS-1:0] pop_tag;
        logic                flush_decoder;
        logic [FILL_W-1:0]   occupancy;
        logic                awaiting_key;
        logic [CNT_W-1:0]    dropped_total;
        logic [CNT_W-1:0]    recovery_total;
        logic [FILL_W-1:0]   peak_occupancy;
    } t_out_word;

endpackage

/* rtl/krpq_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module krpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/keyframe_recovery_packet_queue.sv */
// Top level of the keyframe recovery packet queue: control state, tag RAM and word staging.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//  config  | input     | psel, penable, pwrite      | paddr, pwdata, prdata
//
// The result word of an accepted input word passes through a pending stage and then the output
// register; a pop takes its tag from the registered read of the tag RAM. The pending stage and
// the output register overlap, so one word per cycle is sustained while the output side takes
// words. When the output stalls, at most one further word is taken into the pending stage.
// Synchronous active-low reset empties the queue, clears the counters and sets the limit to
// the queue depth; the tag RAM is not cleared.
module keyframe_recovery_packet_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  krpq_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output krpq_pkg::t_out_word         o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int PTR_W = krpq_pkg::PTR_W;
    localparam int FILL_W = krpq_pkg::FILL_W;
    localparam int CNT_W = krpq_pkg::CNT_W;
    localparam int LIMIT_W = krpq_pkg::LIMIT_W;
    localparam int TAG_BITS = krpq_pkg::TAG_BITS;
    localparam int DEPTH = krpq_pkg::QUEUE_DEPTH;

    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_wait, n_wait;
    logic               r_flush, n_flush;
    logic [CNT_W-1:0]   r_drop, n_drop;
    logic [CNT_W-1:0]   r_rec, n_rec;
    logic [FILL_W-1:0]  r_peak, n_peak;
    logic [LIMIT_W-1:0] r_limit;

    logic                r_pend;
    krpq_pkg::t_out_word r_pend_word, n_pend_word;
    logic                r_out_valid;
    krpq_pkg::t_out_word r_out_word;
    krpq_pkg::t_out_word move_word;

    logic               in_accept;
    logic               out_free;
    logic               move;
    logic [FILL_W-1:0]  lim_eff;
    logic [FILL_W:0]    drop_add;
    logic [CNT_W:0]     drop_sum;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [TAG_BITS-1:0] rd_data;
    logic               do_enq;
    logic               do_discard;
    logic               do_rec;

    assign out_free = !r_out_valid || i_out_ready;
    assign move = r_pend && out_free;
    assign o_in_ready = !r_pend || out_free;
    assign in_accept = i_in_valid && o_in_ready;

    always_comb begin
        if (r_limit == '0) begin
            lim_eff = FILL_W'(1);
        end else if (FILL_W'(r_limit) > FILL_W'(DEPTH)) begin
            lim_eff = FILL_W'(DEPTH);
        end else begin
            lim_eff = FILL_W'(r_limit);
        end
    end

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        n_wait = r_wait;
        n_flush = r_flush;
        n_peak = r_peak;
        n_rec = r_rec;
        drop_add = '0;
        do_enq = 1'b0;
        do_discard = 1'b0;
        do_rec = 1'b0;
        rd_en = 1'b0;
        n_pend_word = '0;
        case (i_in_word.action)
            krpq_pkg::ACT_PUSH: begin
                if (r_wait) begin
                    if (i_in_word.key_frame) begin
                        do_discard = 1'b1;
                        do_enq = 1'b1;
                        n_wait = 1'b0;
                        n_flush = 1'b1;
                    end else begin
                        drop_add = (FILL_W + 1)'(1);
                    end
                end else if (r_fill >= lim_eff) begin
                    do_discard = 1'b1;
                    do_rec = 1'b1;
                    if (i_in_word.key_frame) begin
                        do_enq = 1'b1;
                        n_flush = 1'b1;
                    end else begin
                        n_wait = 1'b1;
                        drop_add = (FILL_W + 1)'(1);
                    end
                end else begin
                    do_enq = 1'b1;
                end
                if (do_discard) begin
                    drop_add = drop_add + (FILL_W + 1)'(r_fill);
                    n_head = '0;
                    n_tail = '0;
                    n_fill = '0;
                end
                if (do_enq) begin
                    n_tail = next_ptr(do_discard ? '0 : r_tail);
                    n_fill = (do_discard ? '0 : r_fill) + FILL_W'(1);
                    n_peak = (n_fill > r_peak) ? n_fill : r_peak;
                end
                n_pend_word.accepted = do_enq;
            end
            krpq_pkg::ACT_POP: begin
                if (r_fill != '0) begin
                    rd_en = 1'b1;
                    n_head = next_ptr(r_head);
                    n_fill = r_fill - FILL_W'(1);
                    n_flush = 1'b0;
                    n_pend_word.pop_valid = 1'b1;
                    n_pend_word.flush_decoder = r_flush;
                end
            end
            krpq_pkg::ACT_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_fill = '0;
                n_wait = 1'b0;
            end
            default: begin
            end
        endcase
        drop_sum = {1'b0, r_drop} + (CNT_W + 1)'(drop_add);
        n_drop = drop_sum[CNT_W] ? '1 : drop_sum[CNT_W-1:0];
        if (do_rec && (r_rec != '1)) begin
            n_rec = r_rec + CNT_W'(1);
        end
        n_pend_word.occupancy = n_fill;
        n_pend_word.awaiting_key = n_wait;
        n_pend_word.dropped_total = n_drop;
        n_pend_word.recovery_total = n_rec;
        n_pend_word.peak_occupancy = n_peak;
    end

    assign wr_en = in_accept && do_enq;
    assign wr_addr = do_discard ? '0 : r_tail;

    krpq_ram #(
        .WIDTH(TAG_BITS),
        .DEPTH(DEPTH)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_word.packet_tag),
        .i_rd_en   (in_accept && rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_wait <= 1'b0;
            r_flush <= 1'b0;
            r_drop <= '0;
            r_rec <= '0;
            r_peak <= '0;
            r_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_fill <= n_fill;
                r_wait <= n_wait;
                r_flush <= n_flush;
                r_drop <= n_drop;
                r_rec <= n_rec;
                r_peak <= n_peak;
            end
            if (in_accept) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        move_word = r_pend_word;
        move_word.pop_tag = r_pend_word.pop_valid ? rd_data : '0;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pend_word <= n_pend_word;
        end
        if (move) begin
            r_out_word <= move_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= krpq_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == krpq_pkg::REG_QUEUE_LIMIT)) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out_word;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == krpq_pkg::REG_QUEUE_LIMIT) ? 32'(r_limit) : '0;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the keyframe recovery packet queue with its own queue predictor.
module testbench;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_QUEUE_LIMIT = {krpq_pkg::REG_QUEUE_LIMIT, 2'b00};
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS = 240;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    krpq_pkg::t_in_word   i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    krpq_pkg::t_out_word  o_out_word;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_target = 0;
    int hold_count = 0;
    int idle_cycles = 0;
    int errors = 0;

    logic [krpq_pkg::TAG_BITS-1:0] tag_mem [krpq_pkg::QUEUE_DEPTH];
    int unsigned                   head_idx;
    int unsigned                   tail_idx;
    int unsigned                   fill_level;
    bit                            waiting_for_key;
    bit                            flush_armed;
    logic [krpq_pkg::CNT_W-1:0]    drop_count;
    logic [krpq_pkg::CNT_W-1:0]    recovery_count;
    int unsigned                   peak_level;
    logic [krpq_pkg::LIMIT_W-1:0]  limit_reg;
    krpq_pkg::t_out_word           expected_words[$];

    keyframe_recovery_packet_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [krpq_pkg::CNT_W-1:0] sat_add(logic [krpq_pkg::CNT_W-1:0] a,
                                                           int unsigned b);
        logic [krpq_pkg::CNT_W:0] sum;
        sum = {1'b0, a} + (krpq_pkg::CNT_W+1)'(b);
        return sum[krpq_pkg::CNT_W] ? '1 : sum[krpq_pkg::CNT_W-1:0];
    endfunction

    function automatic void discard_queue();
        drop_count = sat_add(drop_count, fill_level);
        head_idx = 0;
        tail_idx = 0;
        fill_level = 0;
    endfunction

    function automatic void enqueue_tag(logic [krpq_pkg::TAG_BITS-1:0] tag);
        tag_mem[tail_idx] = tag;
        tail_idx = (tail_idx + 1) % krpq_pkg::QUEUE_DEPTH;
        fill_level++;
        if (fill_level > peak_level) begin
            peak_level = fill_level;
        end
    endfunction

    function automatic void predict_queue_step(krpq_pkg::t_in_word w);
        krpq_pkg::t_out_word r;
        int unsigned         lim;
        r = '0;
        lim = (limit_reg == 0) ? 1 : ((limit_reg > krpq_pkg::QUEUE_DEPTH)
                                      ? krpq_pkg::QUEUE_DEPTH : limit_reg);
        case (w.action)
            krpq_pkg::ACT_PUSH: begin
                if (waiting_for_key) begin
                    if (w.key_frame) begin
                        discard_queue();
                        enqueue_tag(w.packet_tag);
                        r.accepted = 1'b1;
                        waiting_for_key = 1'b0;
                        flush_armed = 1'b1;
                    end else begin
                        drop_count = sat_add(drop_count, 1);
                    end
                end else if (fill_level >= lim) begin
                    discard_queue();
                    recovery_count = sat_add(recovery_count, 1);
                    if (w.key_frame) begin
                        enqueue_tag(w.packet_tag);
                        r.accepted = 1'b1;
                        flush_armed = 1'b1;
                    end else begin
                        waiting_for_key = 1'b1;
                        drop_count = sat_add(drop_count, 1);
                    end
                end else begin
                    enqueue_tag(w.packet_tag);
                    r.accepted = 1'b1;
                end
            end
            krpq_pkg::ACT_POP: begin
                if (fill_level > 0) begin
                    r.pop_valid = 1'b1;
                    r.pop_tag = tag_mem[head_idx];
                    head_idx = (head_idx + 1) % krpq_pkg::QUEUE_DEPTH;
                    fill_level--;
                    r.flush_decoder = flush_armed;
                    flush_armed = 1'b0;
                end
            end
            krpq_pkg::ACT_CLEAR: begin
                head_idx = 0;
                tail_idx = 0;
                fill_level = 0;
                waiting_for_key = 1'b0;
            end
            default: begin
            end
        endcase
        r.occupancy = krpq_pkg::FILL_W'(fill_level);
        r.awaiting_key = waiting_for_key;
        r.dropped_total = drop_count;
        r.recovery_total = recovery_count;
        r.peak_occupancy = krpq_pkg::FILL_W'(peak_level);
        expected_words.push_back(r);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_word(krpq_pkg::t_out_word got);
        krpq_pkg::t_out_word want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            errors++;
        end else begin
            want = expected_words.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("pop_valid", want.pop_valid, got.pop_valid);
            compare_field("pop_tag", want.pop_tag, got.pop_tag);
            compare_field("flush_decoder", want.flush_decoder, got.flush_decoder);
            compare_field("occupancy", want.occupancy, got.occupancy);
            compare_field("awaiting_key", want.awaiting_key, got.awaiting_key);
            compare_field("dropped_total", want.dropped_total, got.dropped_total);
            compare_field("recovery_total", want.recovery_total, got.recovery_total);
            compare_field("peak_occupancy", want.peak_occupancy, got.peak_occupancy);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_word(o_out_word);
        end
        if (hold_count < hold_target) begin
            i_out_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("keyframe_recovery_packet_queue test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(krpq_pkg::t_in_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_queue_step(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_queue_limit(logic [6:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_QUEUE_LIMIT;
        pwdata <= {25'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_reg = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic krpq_pkg::t_in_word make_word(logic [1:0] action, logic [15:0] tag,
                                                     logic key);
        krpq_pkg::t_in_word w;
        w.action = action;
        w.packet_tag = tag;
        w.key_frame = key;
        return w;
    endfunction

    function automatic krpq_pkg::t_in_word random_word(int push_pct);
        int r;
        r = $urandom_range(99);
        return make_word((r < push_pct) ? krpq_pkg::ACT_PUSH : (r < 94) ? krpq_pkg::ACT_POP
                         : (r < 97) ? krpq_pkg::ACT_CLEAR : ACT_UNUSED,
                         16'($urandom), $urandom_range(99) < 12);
    endfunction

    task automatic run_random_phase(int n_words, int idle_pct, int stall);
        int push_pct;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        for (int i = 0; i < n_words; i++) begin
            if (i % 20 == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 90;
                    1: push_pct = 65;
                    default: push_pct = 35;
                endcase
            end
            send_word(random_word(push_pct));
        end
        drain();
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_word(make_word(krpq_pkg::ACT_POP, 16'h0000, 1'b0));
        send_word(make_word(ACT_UNUSED, 16'hFFFF, 1'b1));
        send_word(make_word(krpq_pkg::ACT_CLEAR, 16'hFFFF, 1'b1));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h0000, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'hFFFF, 1'b1));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'hAAAA, 1'b0));
        send_word(make_word(krpq_pkg::ACT_POP, 16'h0000, 1'b0));
        send_word(make_word(krpq_pkg::ACT_POP, 16'h0000, 1'b0));
        drain();
        write_queue_limit(7'd2);
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h5555, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h1234, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h1111, 1'b0));
        send_word(make_word(krpq_pkg::ACT_POP, 16'h0000, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h2222, 1'b1));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h3333, 1'b1));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h4444, 1'b1));
        send_word(make_word(krpq_pkg::ACT_POP, 16'h0000, 1'b0));
        send_word(make_word(krpq_pkg::ACT_POP, 16'h0000, 1'b0));
        send_word(make_word(krpq_pkg::ACT_POP, 16'h0000, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h0007, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h0008, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h0009, 1'b0));
        send_word(make_word(krpq_pkg::ACT_CLEAR, 16'h0000, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h000A, 1'b0));
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h000B, 1'b0));
        drain();
        write_queue_limit(7'd0);
        send_word(make_word(krpq_pkg::ACT_PUSH, 16'h7FFF, 1'b1));
        send_word(make_word(krpq_pkg::ACT_POP, 16'h0000, 1'b0));
        drain();
    endtask

    task automatic test_open_flow();
        write_queue_limit(7'd64);
        run_random_phase(PHASE_WORDS, 0, 0);
    endtask

    task automatic test_sparse_sender();
        write_queue_limit(7'd127);
        run_random_phase(PHASE_WORDS, 76, 0);
    endtask

    task automatic test_stalled_receiver();
        write_queue_limit(7'($urandom_range(1, 16)));
        run_random_phase(PHASE_WORDS, 0, 76);
    endtask

    task automatic test_mixed_idling();
        write_queue_limit(7'd0);
        run_random_phase(PHASE_WORDS, 12, 12);
    endtask

    task automatic test_any_limit();
        write_queue_limit(7'($urandom_range(0, 127)));
        run_random_phase(PHASE_WORDS, 0, 0);
    endtask

    task automatic test_backpressure();
        write_queue_limit(7'd8);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_target = 100;
        for (int i = 0; i < 40; i++) begin
            send_word(random_word(65));
        end
        drain();
    endtask

    initial begin
        head_idx = 0;
        tail_idx = 0;
        fill_level = 0;
        waiting_for_key = 1'b0;
        flush_armed = 1'b0;
        drop_count = '0;
        recovery_count = '0;
        peak_level = 0;
        limit_reg = krpq_pkg::LIMIT_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_open_flow();
        test_sparse_sender();
        test_stalled_receiver();
        test_mixed_idling();
        test_any_limit();
        test_backpressure();
        if (errors == 0) begin
            $display("keyframe_recovery_packet_queue test passed");
        end else begin
            $display("keyframe_recovery_packet_queue test failed");
        end
        $finish;
    end

endmodule

/* keyframe_recovery_packet_queue.f */
rtl/krpq_pkg.sv
rtl/krpq_ram.sv
rtl/keyframe_recovery_packet_queue.sv
dv/testbench.sv
